### src/cupr_pkg.sv
// ----------------------------------------------------------------------------
// cupr_pkg: shared definitions for the CSS url() prefix rewriter
// Lexer modes, character codes, register indexes and the control/status
// structs exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package cupr_pkg;

    localparam int URL_WINDOW_DEF = 6;
    localparam int PREFIX_MAX_DEF = 8;

    localparam int BYTE_W     = 8;
    localparam int PREFIX_W   = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int HTTP_LEN   = 5;
    localparam int HTTPS_LEN  = 6;
    localparam int SLASH_LEN  = 1;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef enum logic [2:0] {
        MODE_DEFAULT = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_URL     = 3'd2,
        MODE_SINGLE  = 3'd3,
        MODE_DOUBLE  = 3'd4
    } lex_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREFIX_BYTES  = 1'b0,
        REG_PREFIX_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_FLUSH
    } act_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PREFIX,
        SRC_HOLD,
        SRC_TAIL
    } out_src_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_HOLD,
        ST_TAIL
    } ctrl_state_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_src_t sel;
        logic     last;
        logic     idx_clr;
        logic     idx_inc;
        logic     cnt_clr;
    } cupr_cmd_t;

    typedef struct packed {
        act_t act;
        logic tail;
        logic skip_prefix;
        logic plen_zero;
        logic pre_last;
        logic hold_empty;
        logic hold_last;
        logic out_free;
    } cupr_stat_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // Characters of "https:" by position.
    function automatic logic [7:0] https_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = CH_H;
            3'd1: r = CH_T;
            3'd2: r = CH_T;
            3'd3: r = CH_P;
            3'd4: r = CH_S;
            default: r = CH_COLON;
        endcase
        return r;
    endfunction

    // Characters of "http:" by position.
    function automatic logic [7:0] http_char(input logic [2:0] i);
        logic [7:0] r;
        r = (i == 3'd4) ? CH_COLON : https_char(i);
        return r;
    endfunction

endpackage

### src/cupr_dp.sv
// ----------------------------------------------------------------------------
// cupr_dp: datapath of the CSS url() prefix rewriter
// Lexer state, url hold memory, prefix match flags, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module cupr_dp
    import cupr_pkg::*;
#(
    parameter int URL_WINDOW = URL_WINDOW_DEF,
    parameter int PREFIX_MAX = PREFIX_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [BYTE_W-1:0]    s_in_byte,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PREFIX_W-1:0]  cfg_data,
    input  cupr_cmd_t            cmd,
    output cupr_stat_t           stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic                 m_run_last
);

    localparam int HW    = (URL_WINDOW > 1) ? $clog2(URL_WINDOW) : 1;
    localparam int CW    = $clog2(URL_WINDOW + 1);
    localparam int PIW   = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
    localparam int PW    = $clog2(PREFIX_MAX + 1);
    localparam int IDX_W = (HW > PIW) ? HW : PIW;
    localparam int MW1   = (IDX_W > CW) ? IDX_W : CW;
    localparam int CMPW  = ((MW1 > PW) ? MW1 : PW) + 1;

    lex_mode_t lex_mode_reg, lex_mode_next;
    lex_mode_t saved_mode_reg, saved_mode_next;
    logic      collecting_reg, collecting_next;
    logic [BYTE_W-1:0] p1_reg, p2_reg, p3_reg;
    logic [CW-1:0]     hold_count_reg, hold_count_next;
    logic      slash_reg, slash_next;
    logic      http_reg, http_next;
    logic      https_reg, https_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PREFIX_MAX-1:0][BYTE_W-1:0] prefix_bytes_reg;
    logic [LEN_W-1:0]  prefix_length_reg;
    logic      m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic      m_last_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] url_hold_mem [URL_WINDOW];

    act_t      dec_act;
    logic      dec_tail;
    logic      dec_hold;
    logic      dec_open;
    logic      no_echo;
    logic      hold_full;
    logic [BYTE_W-1:0] lc;
    logic [PW-1:0]     plen;
    logic [HW-1:0]     rd_addr;
    logic [BYTE_W-1:0] out_sel;
    logic      out_free;

    assign lc        = lower_byte(s_in_byte);
    assign hold_full = (hold_count_reg == CW'(URL_WINDOW - 1));
    assign out_free  = !m_valid_reg || m_ready;

    // Lexer decode for the byte on the input channel.
    always_comb begin
        lex_mode_next   = lex_mode_reg;
        saved_mode_next = saved_mode_reg;
        collecting_next = collecting_reg;
        dec_act  = ACT_NONE;
        dec_tail = 1'b0;
        dec_hold = 1'b0;
        dec_open = 1'b0;
        no_echo  = 1'b0;
        if (lex_mode_reg != MODE_COMMENT && s_in_byte == CH_STAR && p1_reg == CH_SLASH) begin
            saved_mode_next = lex_mode_reg;
            lex_mode_next   = MODE_COMMENT;
        end else if (lex_mode_reg == MODE_COMMENT && s_in_byte == CH_SLASH
                     && p1_reg == CH_STAR) begin
            lex_mode_next   = saved_mode_reg;
            saved_mode_next = MODE_DEFAULT;
        end else if ((lex_mode_reg inside {MODE_DEFAULT, MODE_URL})
                     && (s_in_byte == CH_DQUOTE || s_in_byte == CH_SQUOTE)) begin
            saved_mode_next = lex_mode_reg;
            lex_mode_next   = (s_in_byte == CH_DQUOTE) ? MODE_DOUBLE : MODE_SINGLE;
            if (collecting_reg) begin
                dec_act = ACT_ECHO;
            end
        end else if (((lex_mode_reg == MODE_DOUBLE && s_in_byte == CH_DQUOTE)
                      || (lex_mode_reg == MODE_SINGLE && s_in_byte == CH_SQUOTE))
                     && p1_reg != CH_BSLASH) begin
            lex_mode_next   = saved_mode_reg;
            saved_mode_next = MODE_DEFAULT;
            dec_hold        = collecting_reg;
        end else if (lex_mode_reg == MODE_DEFAULT && s_in_byte == CH_LPAREN
                     && lower_byte(p3_reg) == CH_U && lower_byte(p2_reg) == CH_R
                     && lower_byte(p1_reg) == CH_L) begin
            lex_mode_next   = MODE_URL;
            collecting_next = 1'b1;
            dec_open        = 1'b1;
            dec_act         = ACT_ECHO;
        end else if (lex_mode_reg == MODE_URL && s_in_byte == CH_RPAREN) begin
            lex_mode_next = MODE_DEFAULT;
            if (collecting_reg) begin
                collecting_next = 1'b0;
                dec_act         = ACT_FLUSH;
            end
        end else if ((lex_mode_reg == MODE_URL || saved_mode_reg == MODE_URL)
                     && collecting_reg) begin
            dec_hold = 1'b1;
        end

        // A byte that fills the hold flushes it and is not echoed again.
        if (dec_hold && hold_full) begin
            collecting_next = 1'b0;
            dec_act         = ACT_FLUSH;
            no_echo         = 1'b1;
        end

        if (!collecting_next && !no_echo) begin
            if (dec_act == ACT_FLUSH) begin
                dec_tail = 1'b1;
            end else begin
                dec_act = ACT_ECHO;
            end
        end
    end

    // Prefix match flags follow the held bytes as they arrive.
    always_comb begin
        slash_next = slash_reg;
        http_next  = http_reg;
        https_next = https_reg;
        if (hold_count_reg == '0) begin
            slash_next = (lc == CH_SLASH);
            http_next  = (lc == http_char(3'd0));
            https_next = (lc == https_char(3'd0));
        end else begin
            http_next  = http_reg && (hold_count_reg >= CW'(HTTP_LEN)
                                      || lc == http_char(hold_count_reg[2:0]));
            https_next = https_reg && (hold_count_reg >= CW'(HTTPS_LEN)
                                       || lc == https_char(hold_count_reg[2:0]));
        end
    end

    always_comb begin
        hold_count_next = hold_count_reg;
        if (cmd.cnt_clr) begin
            hold_count_next = '0;
        end else if (cmd.accept && dec_open) begin
            hold_count_next = '0;
        end else if (cmd.accept && dec_hold) begin
            hold_count_next = hold_count_reg + CW'(1);
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign rd_addr = (CMPW'(idx_next) < CMPW'(URL_WINDOW)) ? idx_next[HW-1:0] : '0;

    assign plen = (prefix_length_reg > LEN_W'(PREFIX_MAX)) ? PW'(PREFIX_MAX)
                                                           : PW'(prefix_length_reg);

    always_comb begin
        case (cmd.sel)
            SRC_INPUT:  out_sel = s_in_byte;
            SRC_PREFIX: out_sel = prefix_bytes_reg[idx_reg[PIW-1:0]];
            SRC_HOLD:   out_sel = rd_data_reg;
            SRC_TAIL:   out_sel = p1_reg;
            default:    out_sel = s_in_byte;
        endcase
    end

    always_comb begin
        stat.act         = dec_act;
        stat.tail        = dec_tail;
        stat.skip_prefix = (hold_count_reg >= CW'(SLASH_LEN) && slash_reg)
                         || (hold_count_reg >= CW'(HTTP_LEN) && http_reg)
                         || (hold_count_reg >= CW'(HTTPS_LEN) && https_reg);
        stat.plen_zero   = (plen == '0);
        stat.pre_last    = (CMPW'(idx_reg) + CMPW'(1) == CMPW'(plen));
        stat.hold_empty  = (hold_count_reg == '0);
        stat.hold_last   = (CMPW'(idx_reg) + CMPW'(1) == CMPW'(hold_count_reg));
        stat.out_free    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode_reg      <= MODE_DEFAULT;
            saved_mode_reg    <= MODE_DEFAULT;
            collecting_reg    <= 1'b0;
            p1_reg            <= '0;
            p2_reg            <= '0;
            p3_reg            <= '0;
            hold_count_reg    <= '0;
            slash_reg         <= 1'b0;
            http_reg          <= 1'b0;
            https_reg         <= 1'b0;
            idx_reg           <= '0;
            prefix_bytes_reg  <= '0;
            prefix_length_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cmd.accept) begin
                lex_mode_reg   <= lex_mode_next;
                saved_mode_reg <= saved_mode_next;
                collecting_reg <= collecting_next;
                p1_reg         <= s_in_byte;
                p2_reg         <= p1_reg;
                p3_reg         <= p2_reg;
                if (dec_hold) begin
                    slash_reg <= slash_next;
                    http_reg  <= http_next;
                    https_reg <= https_next;
                end
            end
            hold_count_reg <= hold_count_next;
            idx_reg        <= idx_next;
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PREFIX_BYTES:  prefix_bytes_reg  <= cfg_data[PREFIX_MAX*BYTE_W-1:0];
                    REG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_byte_reg <= out_sel;
            m_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && dec_hold) begin
            url_hold_mem[hold_count_reg[HW-1:0]] <= s_in_byte;
        end
        rd_data_reg <= url_hold_mem[rd_addr];
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_run_last = m_last_reg;

endmodule

### src/cupr_ctrl.sv
// ----------------------------------------------------------------------------
// cupr_ctrl: sequencing controller of the CSS url() prefix rewriter
// Accepts input bytes and steps a url flush through prefix, held bytes
// and the closing parenthesis.
// ----------------------------------------------------------------------------
module cupr_ctrl
    import cupr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cupr_stat_t stat,
    output cupr_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        tail_reg, tail_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tail_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tail_next  = tail_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.sel    = SRC_INPUT;
        case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    cmd.accept = 1'b1;
                    case (stat.act)
                        ACT_ECHO: begin
                            cmd.load = 1'b1;
                            cmd.sel  = SRC_INPUT;
                            cmd.last = 1'b1;
                        end
                        ACT_FLUSH: begin
                            tail_next   = stat.tail;
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_PREFIX;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREFIX: begin
                if (stat.skip_prefix || stat.plen_zero) begin
                    state_next = ST_HOLD;
                end else if (stat.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SRC_PREFIX;
                    cmd.last = stat.pre_last && stat.hold_empty && !tail_reg;
                    if (stat.pre_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_HOLD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                if (stat.hold_empty) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tail_reg ? ST_TAIL : ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SRC_HOLD;
                    cmd.last = stat.hold_last && !tail_reg;
                    if (stat.hold_last) begin
                        cmd.idx_clr = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_next  = tail_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SRC_TAIL;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/css_url_prefix_rewriter.sv
// ----------------------------------------------------------------------------
// css_url_prefix_rewriter: CSS url() prefix rewriter, top level
// Echoes CSS text byte by byte and inserts a configured prefix in front of
// relative url() targets.
// ----------------------------------------------------------------------------
// Output: an echoed byte is registered onto m_ and is there in the cycle after its input
// transfer; a url flush sends the prefix bytes, unless the prefix is skipped or empty,
// then the held bytes, then ")" when the url closed with one.
// Throughput: one input byte per cycle when it echoes, holds or drops the byte, while
// the output is free; no input is taken while a url flush is in progress.
// Reset clears lexer state, hold count, configuration and output valid, not the hold.
module css_url_prefix_rewriter
    import cupr_pkg::*;
#(
    parameter int URL_WINDOW = URL_WINDOW_DEF,
    parameter int PREFIX_MAX = PREFIX_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic                 m_run_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PREFIX_W-1:0]  cfg_data
);

    cupr_cmd_t  cmd;
    cupr_stat_t stat;

    // Configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    cupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cupr_dp #(
        .URL_WINDOW (URL_WINDOW),
        .PREFIX_MAX (PREFIX_MAX)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_in_byte  (s_in_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule

### src/cupr_checker.sv
// ----------------------------------------------------------------------------
// cupr_checker: port-level checks for the CSS url() prefix rewriter
// Watches the handshakes and the run framing of the result stream.
// ----------------------------------------------------------------------------
module cupr_checker
    import cupr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_out_byte,
    input logic              m_run_last
);

    logic run_open_reg, run_open_next;

    // A run is open after a transfer without the last flag.
    always_comb begin
        run_open_next = run_open_reg;
        if (m_valid && m_ready) begin
            run_open_next = !m_run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg <= 1'b0;
        end else begin
            run_open_reg <= run_open_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg && !(m_valid && m_ready) |-> !s_ready)
        else $error("input ready while a result run is open");

    // Input may only be taken during an open run at the edge its last byte leaves.
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && run_open_reg |-> m_valid && m_ready && m_run_last)
        else $error("input taken before the previous run ended");

endmodule

bind css_url_prefix_rewriter cupr_checker u_cupr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_run_last (m_run_last)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CSS url() prefix rewriter
// Streams CSS text into the rewriter under several prefix settings and
// checks every output byte and its last-of-run flag against a byte-level
// model of the lexer, the url hold and the prefix insertion rules.
// ----------------------------------------------------------------------------
module tb;
    import cupr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_DEPTH = URL_WINDOW_DEF;
    localparam int PFX_LIMIT  = PREFIX_MAX_DEF;
    localparam int PHASES     = 6;
    localparam int PHASE_LOAD = 72;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_run_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_reg_t          cfg_index = REG_PREFIX_BYTES;
    logic [PREFIX_W-1:0] cfg_data = '0;

    css_url_prefix_rewriter dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expected output.
    logic [7:0] css_src_q[$];
    out_beat_t  rewrite_q[$];

    // Model of the rewriter.
    lex_mode_t   mode_q = MODE_DEFAULT;
    lex_mode_t   ret_mode_q = MODE_DEFAULT;
    bit          gather_q = 1'b0;
    logic [7:0]  hist_q[3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]  url_buf[HOLD_DEPTH];
    int          hold_n = 0;
    logic [63:0] pfx_bytes = '0;
    logic [3:0]  pfx_len = '0;

    int  err_count = 0;
    int  queued_n = 0;
    int  sent_n = 0;
    int  checked_n = 0;
    int  flush_n = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  ready_run = 0;
    bit  idle_on = 1'b1;
    int  stall_style = 0;

    task automatic report_mismatch(input string what);
        if (err_count < 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        err_count++;
    endtask

    function automatic logic [7:0] fold_case(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    endfunction

    function automatic void put_out(input logic [7:0] ch);
        rewrite_q.push_back('{ch, 1'b0});
    endfunction

    function automatic bit held_lead_is(input string pat);
        if (hold_n < pat.len()) begin
            return 1'b0;
        end
        for (int i = 0; i < pat.len(); i++) begin
            if (fold_case(url_buf[i]) != pat[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void flush_url();
        int plen;
        if (!(held_lead_is("/") || held_lead_is("http:") || held_lead_is("https:"))) begin
            plen = (pfx_len > PFX_LIMIT) ? PFX_LIMIT : int'(pfx_len);
            for (int i = 0; i < plen; i++) begin
                put_out(pfx_bytes[8*i +: 8]);
            end
        end
        for (int i = 0; i < hold_n; i++) begin
            put_out(url_buf[i]);
        end
        hold_n = 0;
        gather_q = 1'b0;
        flush_n++;
    endfunction

    // Returns 1 when the byte filled the hold and the url went out with it.
    function automatic bit hold_url_byte(input logic [7:0] ch);
        if (hold_n < HOLD_DEPTH) begin
            url_buf[hold_n] = ch;
            hold_n++;
        end
        if (hold_n >= HOLD_DEPTH) begin
            flush_url();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void rewrite_byte(input logic [7:0] c);
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        bit         quiet;
        int         n0;
        p1 = hist_q[0];
        p2 = hist_q[1];
        p3 = hist_q[2];
        quiet = 1'b0;
        n0 = rewrite_q.size();
        if (mode_q != MODE_COMMENT && c == CH_STAR && p1 == CH_SLASH) begin
            ret_mode_q = mode_q;
            mode_q = MODE_COMMENT;
        end else if (mode_q == MODE_COMMENT && c == CH_SLASH && p1 == CH_STAR) begin
            mode_q = ret_mode_q;
            ret_mode_q = MODE_DEFAULT;
        end else if ((mode_q == MODE_DEFAULT || mode_q == MODE_URL) &&
                     (c == CH_DQUOTE || c == CH_SQUOTE)) begin
            ret_mode_q = mode_q;
            mode_q = (c == CH_DQUOTE) ? MODE_DOUBLE : MODE_SINGLE;
            if (gather_q) begin
                put_out(c);
            end
        end else if (((mode_q == MODE_DOUBLE && c == CH_DQUOTE) ||
                      (mode_q == MODE_SINGLE && c == CH_SQUOTE)) && p1 != CH_BSLASH) begin
            mode_q = ret_mode_q;
            ret_mode_q = MODE_DEFAULT;
            if (gather_q) begin
                quiet = hold_url_byte(c);
            end
        end else if (mode_q == MODE_DEFAULT && c == CH_LPAREN && fold_case(p3) == CH_U &&
                     fold_case(p2) == CH_R && fold_case(p1) == CH_L) begin
            mode_q = MODE_URL;
            gather_q = 1'b1;
            hold_n = 0;
            put_out(c);
        end else if (mode_q == MODE_URL && c == CH_RPAREN) begin
            mode_q = MODE_DEFAULT;
            if (gather_q) begin
                flush_url();
            end
        end else if ((mode_q == MODE_URL || ret_mode_q == MODE_URL) && gather_q) begin
            quiet = hold_url_byte(c);
        end
        if (!gather_q && !quiet) begin
            put_out(c);
        end
        hist_q[2] = p2;
        hist_q[1] = p1;
        hist_q[0] = c;
        if (rewrite_q.size() > n0) begin
            rewrite_q[rewrite_q.size()-1].last = 1'b1;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps while idle_on is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rewrite_byte(s_in_byte);
                sent_n++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (css_src_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_in_byte <= css_src_q.pop_front();
                    if (idle_on) begin
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 16);
                        end
                        burst_left--;
                        if (burst_left == 0) begin
                            gap_left = $urandom_range(1, 7);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transfer and stalls according to stall_style.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                checked_n++;
                if (rewrite_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_out_byte));
                end else begin
                    want = rewrite_q.pop_front();
                    if (m_out_byte !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                                  m_out_byte, want.data));
                    end
                    if (m_run_last !== want.last) begin
                        report_mismatch($sformatf("run_last %0b, wanted %0b on byte %02h",
                                                  m_run_last, want.last, want.data));
                    end
                end
            end
            case (stall_style)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    // Alternating runs of ready and stall with random lengths.
                    if (ready_run <= 0) begin
                        ready_run = $urandom_range(1, 6);
                        m_ready <= !m_ready;
                    end
                    ready_run--;
                end
            endcase
        end
    end

    function automatic logic [7:0] mix_case(input logic [7:0] ch);
        if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) begin
            return ch - 8'd32;
        end
        return ch;
    endfunction

    task automatic push_byte(input logic [7:0] ch);
        css_src_q.push_back(ch);
        queued_n++;
    endtask

    task automatic push_text(input string s, input bit mix);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(mix ? mix_case(s[i]) : s[i]);
        end
    endtask

    function automatic logic [7:0] url_char();
        string alpha;
        int    r;
        alpha = "abcxyz019./-_?=&#%";
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 8'($urandom_range(0, 255));
        end else if (r < 16) begin
            return ($urandom_range(0, 1)) ? CH_SQUOTE : CH_DQUOTE;
        end else if (r < 19) begin
            return CH_STAR;
        end
        return alpha[$urandom_range(0, alpha.len() - 1)];
    endfunction

    // Appends one fragment of CSS-like text; url() openings dominate.
    task automatic add_fragment();
        int         r;
        int         n;
        logic [7:0] q;
        string      plain;
        plain = "ab z{};:#.-0 9\n";
        r = $urandom_range(0, 99);
        if (r < 45) begin
            push_text("url(", 1'b1);
            q = 8'h00;
            if ($urandom_range(0, 3) == 0) begin
                q = ($urandom_range(0, 1)) ? CH_SQUOTE : CH_DQUOTE;
                push_byte(q);
            end
            case ($urandom_range(0, 5))
                0: push_text("/", 1'b0);
                1: push_text("http:", 1'b1);
                2: push_text("https:", 1'b1);
                3: push_text("htt", 1'b1);
                default: ;
            endcase
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                push_byte(url_char());
            end
            if ($urandom_range(0, 4) == 0) begin
                push_text("/*c*/", 1'b0);
            end
            if (q != 8'h00) begin
                push_byte(q);
            end
            if ($urandom_range(0, 6) != 0) begin
                push_byte(CH_RPAREN);
            end
        end else if (r < 58) begin
            q = ($urandom_range(0, 1)) ? CH_SQUOTE : CH_DQUOTE;
            push_byte(q);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                push_byte(plain[$urandom_range(0, plain.len() - 1)]);
            end
            if ($urandom_range(0, 3) == 0) begin
                push_byte(CH_BSLASH);
                push_byte(q);
            end
            push_byte(q);
        end else if (r < 68) begin
            push_text("/*", 1'b0);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                push_byte(url_char());
            end
            push_text("*/", 1'b0);
        end else if (r < 88) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                push_byte(plain[$urandom_range(0, plain.len() - 1)]);
            end
        end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        if (idx == REG_PREFIX_BYTES) begin
            pfx_bytes = val;
        end else begin
            pfx_len = val[3:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (css_src_q.size() != 0 || s_valid || rewrite_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        logic [63:0] ph_bytes[PHASES];
        logic [3:0]  ph_len[PHASES];
        int          target;
        ph_bytes[0] = 64'h0000_0000_2F6E_6463;
        ph_len[0]   = 4'd4;
        ph_bytes[1] = '1;
        ph_len[1]   = 4'd8;
        ph_bytes[2] = '0;
        ph_len[2]   = 4'd0;
        ph_bytes[3] = {$urandom, $urandom};
        ph_len[3]   = 4'd15;
        ph_bytes[4] = {$urandom, $urandom};
        ph_len[4]   = 4'($urandom_range(1, 7));
        ph_bytes[5] = {$urandom, $urandom};
        ph_len[5]   = 4'd12;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_PREFIX_BYTES, ph_bytes[ph]);
            write_reg(REG_PREFIX_LENGTH, {60'd0, ph_len[ph]});
            stall_style = ph % 3;
            idle_on = (ph != 2);
            if (ph == 0) begin
                // Empty url, comment and quotes inside a url that fill the
                // hold, byte extremes, and an absolute http: target.
                push_text("url()URL(/*x*/'", 1'b0);
                push_byte(8'hFF);
                push_byte(CH_SQUOTE);
                push_byte(8'h00);
                push_byte(CH_RPAREN);
                push_text("uRl(Http:)", 1'b0);
            end
            target = queued_n + PHASE_LOAD / 2;
            while (queued_n < target) begin
                add_fragment();
            end
            // Wait until the input queue and the expected output are empty before adding more.
            wait_drained();
            target = queued_n + PHASE_LOAD / 2;
            while (queued_n < target) begin
                add_fragment();
            end
            wait_drained();
            repeat (4) @(posedge aclk);
        end

        repeat (20) @(posedge aclk);
        $display("Run covered %0d input bytes over %0d prefix settings.", sent_n, PHASES);
        $display("Checked %0d output bytes from %0d url flushes.", checked_n, flush_n);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d bytes still expected.", rewrite_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/cupr_pkg.sv
src/cupr_dp.sv
src/cupr_ctrl.sv
src/css_url_prefix_rewriter.sv
src/cupr_checker.sv
tb/tb.sv
